// ===== rtl/time_slot_ring_writer_assert.svh =====
// Assertion macros for the time-slot ring writer.
// Used by the front and back modules; expects clk and rst in scope.
`ifndef TIME_SLOT_RING_WRITER_ASSERT_SVH
`define TIME_SLOT_RING_WRITER_ASSERT_SVH
`ifndef SYNTHESIS
`define TSRW_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsrw assertion failed");
`define TSRW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsrw assertion failed");
`else
`define TSRW_ASSERT_IMPL(lbl, ante, cons)
`define TSRW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/tsrw_pkg.sv =====
// Shared types and constants for the time-slot ring writer.
// No dependencies.
package tsrw_pkg;

  localparam int TS_W        = 32;
  localparam int DATA_W      = 24;
  localparam int SLOT_W      = 6;
  localparam int NCNT_W      = 7;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_VAL_W   = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 8'd1;
  localparam logic [NCNT_W-1:0]    SLOT_COUNT_RESET = 7'd64;

  typedef struct packed {
    logic [TS_W-1:0]   timestamp_s;
    logic [DATA_W-1:0] element_data;
  } sample_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic [DATA_W-1:0] write_data;
    logic              is_fill;
    logic              last;
  } write_cmd_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_VAL_W-1:0] value;
  } cfg_write_t;

  typedef struct packed {
    logic [TS_W-1:0]   start_time;
    logic [NCNT_W-1:0] slot_count;
  } cfg_regs_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic [SLOT_W-1:0] fill_cnt;
    logic [SLOT_W-1:0] start_slot;
    logic [SLOT_W-1:0] data_slot;
    logic [NCNT_W-1:0] n;
    logic [DATA_W-1:0] data;
  } desc_t;

endpackage

// ===== rtl/tsrw_chan_if.sv =====
// Valid/ready channel carrying one payload word of type T.
// No dependencies.
interface tsrw_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tsrw_mod.sv =====
// Bit-serial remainder unit: dividend mod divisor, one bit per cycle.
// Depends on tsrw_pkg.
module tsrw_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [tsrw_pkg::TS_W-1:0]     dividend,
  input  logic [tsrw_pkg::NCNT_W-1:0]   divisor,
  output logic                          done,
  output logic [tsrw_pkg::SLOT_W-1:0]   result
);

  localparam int STEP_W = $clog2(tsrw_pkg::TS_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(tsrw_pkg::TS_W - 1);

  logic                        busy;
  logic [STEP_W-1:0]           step;
  logic [tsrw_pkg::TS_W-1:0]   shift;
  logic [tsrw_pkg::SLOT_W-1:0] rem;
  logic [tsrw_pkg::NCNT_W-1:0] trial;
  logic [tsrw_pkg::NCNT_W-1:0] trial_next;

  // Bring down one bit, subtract the divisor when it fits.
  always_comb begin
    trial      = {rem, shift[tsrw_pkg::TS_W-1]};
    trial_next = (trial >= divisor) ? (trial - divisor) : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
      end else if (busy && step == LAST_STEP) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      step  <= '0;
      shift <= dividend;
      rem   <= '0;
    end else if (busy) begin
      step  <= step + 1'b1;
      shift <= shift << 1;
      rem   <= trial_next[tsrw_pkg::SLOT_W-1:0];
    end
  end

  assign result = rem;

endmodule

// ===== rtl/tsrw_front.sv =====
// Front end: accepts samples, works out the offset, fill count and slots.
// Depends on tsrw_pkg, tsrw_chan_if, tsrw_mod and the assertion macros.
`include "time_slot_ring_writer_assert.svh"
module tsrw_front #(
  parameter int MAX_SLOTS    = 64,
  parameter int ELEMENT_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  tsrw_pkg::cfg_regs_t regs,
  tsrw_chan_if.sink           samples,
  tsrw_chan_if.source         descs
);

  localparam int KEEP_BITS = (ELEMENT_BITS < tsrw_pkg::DATA_W) ? ELEMENT_BITS
                                                               : tsrw_pkg::DATA_W;
  localparam logic [tsrw_pkg::DATA_W-1:0] DATA_MASK =
    {tsrw_pkg::DATA_W{1'b1}} >> (tsrw_pkg::DATA_W - KEEP_BITS);
  localparam logic [tsrw_pkg::NCNT_W-1:0] N_MAX = tsrw_pkg::NCNT_W'(MAX_SLOTS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CALC  = 3'd1;
  localparam logic [2:0] ST_DIV_P = 3'd2;
  localparam logic [2:0] ST_DIV_O = 3'd3;
  localparam logic [2:0] ST_PUSH  = 3'd4;

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [tsrw_pkg::TS_W-1:0]   prior_offset;
  logic                        prior_valid;
  logic [tsrw_pkg::TS_W-1:0]   offset;
  logic [tsrw_pkg::DATA_W-1:0] data;
  logic [tsrw_pkg::NCNT_W-1:0] n;
  logic [tsrw_pkg::SLOT_W-1:0] fill_cnt;
  logic [tsrw_pkg::SLOT_W-1:0] start_slot;
  logic [tsrw_pkg::SLOT_W-1:0] data_slot;

  logic [tsrw_pkg::TS_W:0]     prior_plus1;
  logic                        jump;
  logic [tsrw_pkg::TS_W-1:0]   gaps;
  logic [tsrw_pkg::NCNT_W-1:0] n_m1;
  logic [tsrw_pkg::SLOT_W-1:0] fill;
  logic [tsrw_pkg::NCNT_W-1:0] n_clamped;

  logic                        mod_go;
  logic [tsrw_pkg::TS_W-1:0]   mod_dividend;
  logic                        mod_done;
  logic [tsrw_pkg::SLOT_W-1:0] mod_result;

  tsrw_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .go       (mod_go),
    .dividend (mod_dividend),
    .divisor  (n),
    .done     (mod_done),
    .result   (mod_result)
  );

  // Clamp the configured slot count into 1..MAX_SLOTS.
  always_comb begin
    priority if (regs.slot_count == '0) begin
      n_clamped = tsrw_pkg::NCNT_W'(1);
    end else if (regs.slot_count > N_MAX) begin
      n_clamped = N_MAX;
    end else begin
      n_clamped = regs.slot_count;
    end
  end

  // Forward jump check and capped fill count.
  always_comb begin
    prior_plus1 = {1'b0, prior_offset} + 1'b1;
    jump        = prior_valid && ({1'b0, offset} > prior_plus1);
    gaps        = offset - prior_plus1[tsrw_pkg::TS_W-1:0];
    n_m1        = n - 1'b1;
    fill        = (gaps > tsrw_pkg::TS_W'(n_m1)) ? n_m1[tsrw_pkg::SLOT_W-1:0]
                                                 : gaps[tsrw_pkg::SLOT_W-1:0];
  end

  always_comb begin
    state_next   = state;
    mod_go       = 1'b0;
    mod_dividend = offset;
    unique case (state)
      ST_IDLE: begin
        if (samples.valid) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        mod_go = 1'b1;
        if (jump) begin
          mod_dividend = prior_plus1[tsrw_pkg::TS_W-1:0];
          state_next   = ST_DIV_P;
        end else begin
          state_next = ST_DIV_O;
        end
      end
      ST_DIV_P: begin
        if (mod_done) begin
          mod_go     = 1'b1;
          state_next = ST_DIV_O;
        end
      end
      ST_DIV_O: begin
        if (mod_done) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (descs.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      prior_offset <= '0;
      prior_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_PUSH && descs.ready) begin
        prior_offset <= offset;
        prior_valid  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      offset <= samples.data.timestamp_s - regs.start_time;
      data   <= samples.data.element_data & DATA_MASK;
      n      <= n_clamped;
    end
    if (state == ST_CALC) begin
      fill_cnt <= jump ? fill : '0;
    end
    if (state == ST_DIV_P && mod_done) begin
      start_slot <= mod_result;
    end
    if (state == ST_DIV_O && mod_done) begin
      data_slot <= mod_result;
    end
  end

  assign samples.ready         = (state == ST_IDLE);
  assign descs.valid           = (state == ST_PUSH);
  assign descs.data.fill_cnt   = fill_cnt;
  assign descs.data.start_slot = start_slot;
  assign descs.data.data_slot  = data_slot;
  assign descs.data.n          = n;
  assign descs.data.data       = data;

  `TSRW_ASSERT_IMPL(a_done_only_waiting, mod_done, (state == ST_DIV_P) || (state == ST_DIV_O))
  `TSRW_ASSERT_IMPL(a_fill_needs_prior, descs.valid && (fill_cnt != '0), prior_valid)

endmodule

// ===== rtl/tsrw_queue.sv =====
// Short FIFO of classified items between the front and back ends.
// Depends on tsrw_pkg and tsrw_chan_if.
module tsrw_queue (
  input  logic        clk,
  input  logic        rst,
  tsrw_chan_if.sink   push,
  tsrw_chan_if.source pop
);

  localparam int PTR_W = $clog2(tsrw_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(tsrw_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(tsrw_pkg::QUEUE_DEPTH);

  tsrw_pkg::desc_t  entries [tsrw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign do_push = push.valid && push.ready;
  assign do_pop  = pop.valid && pop.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.data;
    end
  end

  assign push.ready = (count != FULL);
  assign pop.valid  = (count != '0);
  assign pop.data   = entries[rd_ptr];

endmodule

// ===== rtl/tsrw_back.sv =====
// Back end: turns one classified item into fill writes and a data write.
// Depends on tsrw_pkg, tsrw_chan_if and the assertion macros.
`include "time_slot_ring_writer_assert.svh"
module tsrw_back (
  input  logic        clk,
  input  logic        rst,
  tsrw_chan_if.sink   descs,
  tsrw_chan_if.source writes
);

  logic                        busy;
  logic [tsrw_pkg::NCNT_W-1:0] cur_n;
  logic [tsrw_pkg::SLOT_W-1:0] remaining;
  logic [tsrw_pkg::SLOT_W-1:0] cur_slot;
  logic [tsrw_pkg::SLOT_W-1:0] data_slot;
  logic [tsrw_pkg::DATA_W-1:0] data;
  logic                        out_valid;
  tsrw_pkg::write_cmd_t        out_cmd;
  logic                        load_ok;
  logic                        emit;
  logic [tsrw_pkg::NCNT_W-1:0] slot_inc;

  assign load_ok  = !out_valid || writes.ready;
  assign emit     = busy && load_ok;
  assign slot_inc = {1'b0, cur_slot} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (descs.valid && descs.ready) begin
        busy <= 1'b1;
      end else if (emit && remaining == '0) begin
        busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (writes.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (descs.valid && descs.ready) begin
      cur_n     <= descs.data.n;
      remaining <= descs.data.fill_cnt;
      cur_slot  <= descs.data.start_slot;
      data_slot <= descs.data.data_slot;
      data      <= descs.data.data;
    end else if (emit && remaining != '0) begin
      // Step to the next ring slot, wrap at the slot count.
      remaining <= remaining - 1'b1;
      cur_slot  <= (slot_inc == cur_n) ? '0 : slot_inc[tsrw_pkg::SLOT_W-1:0];
    end
    if (emit) begin
      if (remaining != '0) begin
        out_cmd.slot_index <= cur_slot;
        out_cmd.write_data <= '0;
        out_cmd.is_fill    <= 1'b1;
        out_cmd.last       <= 1'b0;
      end else begin
        out_cmd.slot_index <= data_slot;
        out_cmd.write_data <= data;
        out_cmd.is_fill    <= 1'b0;
        out_cmd.last       <= 1'b1;
      end
    end
  end

  assign descs.ready  = !busy;
  assign writes.valid = out_valid;
  assign writes.data  = out_cmd;

  `TSRW_ASSERT_IMPL(a_fill_in_ring, busy && out_valid && out_cmd.is_fill, {1'b0, out_cmd.slot_index} < cur_n)
  `TSRW_ASSERT_IMPL(a_fill_capped, busy, {1'b0, remaining} < cur_n)
  `TSRW_ASSERT_NEXT(a_data_ends_item, emit && (remaining == '0), !busy && out_valid && out_cmd.last)

endmodule

// ===== rtl/time_slot_ring_writer.sv =====
// Time-slot ring writer. From sample accept to first write valid, an item passes the front's
// calc state, one bit-serial remainder (two when a forward jump brings fills), the queue
// and the back's output register. The front takes a new sample only once its item is pushed,
// so its shared remainder unit sets the rate; the back emits each item's fills, then its data write.
// Reset (rst, synchronous): clears handshakes, queue and history; start_time 0, slot_count 64.
module time_slot_ring_writer #(
  parameter int MAX_SLOTS    = 64,
  parameter int ELEMENT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  tsrw_chan_if.sink   samples,
  tsrw_chan_if.source writes,
  tsrw_chan_if.sink   cfg
);

  // Configuration registers: the user must write them only while the block is idle; nothing in the block enforces this.
  tsrw_pkg::cfg_regs_t regs;

  // Classified items: front pushes, back pops, the queue decouples the two.
  tsrw_chan_if #(.T(tsrw_pkg::desc_t)) front_q ();
  tsrw_chan_if #(.T(tsrw_pkg::desc_t)) q_back ();

  assign cfg.ready = 1'b1;

  // Decode the register index; drop writes beyond the register list.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.start_time <= '0;
      regs.slot_count <= tsrw_pkg::SLOT_COUNT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.data.index)
        tsrw_pkg::REG_START_TIME: regs.start_time <= cfg.data.value;
        tsrw_pkg::REG_SLOT_COUNT:
          regs.slot_count <= cfg.data.value[tsrw_pkg::NCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: offset, forward-jump check, fill cap and both slot remainders.
  tsrw_front #(
    .MAX_SLOTS    (MAX_SLOTS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .samples (samples),
    .descs   (front_q)
  );

  tsrw_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (front_q),
    .pop  (q_back)
  );

  // Back: emit fill writes in ring order, then the data write marked last.
  tsrw_back u_back (
    .clk    (clk),
    .rst    (rst),
    .descs  (q_back),
    .writes (writes)
  );

endmodule
